// ===== rtl/rdu_pkg.sv =====
`timescale 1ns / 1ps

package rdu_pkg;

    // vector format: signed, FRAC fraction bits
    localparam int VEC_WIDTH = 16;
    localparam int FRAC      = VEC_WIDTH - 2;
    localparam int ONE_FX    = 1 << FRAC;
    localparam int HALF_FX   = 1 << (FRAC - 1);

    // internal widths
    localparam int RND_W  = 2 * VEC_WIDTH + 4;  // widest product
    localparam int SAT_W  = VEC_WIDTH + 6;      // widest sum before saturation
    localparam int K_W    = VEC_WIDTH + 5;      // k term, signed
    localparam int RAD_W  = VEC_WIDTH + 4;      // non-negative k
    localparam int ROOT_W = VEC_WIDTH + 1;      // floor sqrt of k at FRAC fraction bits

    // square root pipeline: SQ_BITS root bits per stage
    localparam int SQ_BITS   = 2;
    localparam int SQ_STAGES = (ROOT_W + SQ_BITS - 1) / SQ_BITS;

    // stream widths, padded to whole bytes
    localparam int IN_TW  = ((6 * VEC_WIDTH + 7) / 8) * 8;
    localparam int OUT_TW = ((3 * VEC_WIDTH + 7) / 8) * 8;

    // product scaled down by FRAC bits, rounded half away from zero
    function automatic logic signed [RND_W-1:0] f_round(input logic signed [RND_W-1:0] p);
        logic signed [RND_W-1:0] bias;
        bias = p[RND_W-1] ? RND_W'(HALF_FX - 1) : RND_W'(HALF_FX);
        return (p + bias) >>> FRAC;
    endfunction

    // clamp to the signed vector range
    function automatic logic signed [VEC_WIDTH-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-VEC_WIDTH:0] top;
        top = v[SAT_W-1:VEC_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[VEC_WIDTH-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(VEC_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(VEC_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/refraction_direction_unit_core.sv =====
`timescale 1ns / 1ps

// Refraction direction unit: Snell's law in vector form with total internal reflection.
// Slave stream carries one ray per transaction: ray direction and surface normal,
// six signed Q2.14 components. Master stream returns the refracted direction and
// two flags. Configuration: write index_ratio (index 0) and index_ratio_inverse
// (index 1), unsigned Q2.14, through i_cfg_we / i_cfg_addr / i_cfg_wdata while idle.
// The pipeline has 13 + SQ_STAGES stages (22 at 16-bit vectors): 13 arithmetic stages,
// each with at most one layer of multipliers, plus the square root pipeline that
// resolves two root bits per stage. Throughput is one ray per cycle unless stalled.
// Every stage has its own valid bit and loads when it is empty or its successor loads,
// so bubbles collapse: while the receiver holds m_axis_tready low, new rays are still
// taken until the pipeline is full, and nothing is dropped or duplicated.
// Reset (synchronous, active low) empties the pipeline and sets both index registers
// to 1.0. Total reflection gives a zero vector with total_reflection set.
module refraction_direction_unit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [rdu_pkg::VEC_WIDTH-1:0] i_cfg_wdata,
    // ray input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // ray_dir_x, ray_dir_y, ray_dir_z, normal_x, normal_y, normal_z
    input  logic [rdu_pkg::IN_TW-1:0]     s_axis_tdata,
    // refracted direction output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // refr_x, refr_y, refr_z
    output logic [rdu_pkg::OUT_TW-1:0]    m_axis_tdata,
    // total_reflection, entering
    output logic [1:0]                    m_axis_tuser
);
    import rdu_pkg::*;

    localparam int W = VEC_WIDTH;

    // register indexes
    localparam logic REG_RATIO     = 1'b0;
    localparam logic REG_RATIO_INV = 1'b1;

    // stage positions
    localparam int S_PROD = 0;
    localparam int S_RND  = 1;
    localparam int S_SEL  = 2;
    localparam int S_MUL1 = 3;
    localparam int S_RND1 = 4;
    localparam int S_MUL2 = 5;
    localparam int S_RND2 = 6;
    localparam int S_MUL3 = 7;
    localparam int S_K    = 8;
    localparam int S_SQ0  = 9;
    localparam int S_COEF = S_SQ0 + SQ_STAGES;
    localparam int S_MULN = S_COEF + 1;
    localparam int S_RNDN = S_COEF + 2;
    localparam int S_OUT  = S_COEF + 3;
    localparam int NS     = S_OUT + 1;

    // index registers
    logic [W-1:0] r_eta_lv;
    logic [W-1:0] r_eta_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_lv <= W'(ONE_FX);
            r_eta_en <= W'(ONE_FX);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RATIO:     r_eta_lv <= i_cfg_wdata;
                REG_RATIO_INV: r_eta_en <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when its successor loads
    logic [NS-1:0] r_v;
    logic [NS-1:0] ld;

    always_comb begin
        ld[NS-1] = ~r_v[NS-1] | m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = ~r_v[k] | ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign s_axis_tready = ld[0];

    // unpack input transaction
    logic signed [W-1:0] w_iv [3];
    logic signed [W-1:0] w_nv [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_iv[c] = s_axis_tdata[c*W +: W];
            w_nv[c] = s_axis_tdata[(3+c)*W +: W];
        end
    end

    // stage 0: component products of the dot product
    logic signed [2*W-1:0] r_s0_p  [3];
    logic signed [W-1:0]   r_s0_iv [3];
    logic signed [W-1:0]   r_s0_nv [3];

    always_ff @(posedge i_clk) begin
        if (ld[S_PROD]) begin
            for (int c = 0; c < 3; c++) begin
                r_s0_p[c]  <= w_iv[c] * w_nv[c];
                r_s0_iv[c] <= w_iv[c];
                r_s0_nv[c] <= w_nv[c];
            end
        end
    end

    // stage 1: round the products
    logic signed [W+1:0] r_s1_dr [3];
    logic signed [W-1:0] r_s1_iv [3];
    logic signed [W-1:0] r_s1_nv [3];

    always_ff @(posedge i_clk) begin
        if (ld[S_RND]) begin
            for (int c = 0; c < 3; c++) begin
                r_s1_dr[c] <= (W + 2)'(f_round(RND_W'(r_s0_p[c])));
                r_s1_iv[c] <= r_s0_iv[c];
                r_s1_nv[c] <= r_s0_nv[c];
            end
        end
    end

    // stage 2: dot product, side of the surface, eta and oriented normal
    logic signed [W-1:0] n_dot;
    logic                n_ent;
    logic signed [W:0]   n_dot_x;

    assign n_dot   = f_sat(SAT_W'(r_s1_dr[0]) + SAT_W'(r_s1_dr[1]) + SAT_W'(r_s1_dr[2]));
    assign n_ent   = n_dot[W-1];
    assign n_dot_x = (W + 1)'(n_dot);

    logic                r_s2_ent;
    logic [W-1:0]        r_s2_eta;
    logic signed [W:0]   r_s2_d;
    logic signed [W:0]   r_s2_nvs [3];
    logic signed [W-1:0] r_s2_iv  [3];

    always_ff @(posedge i_clk) begin
        if (ld[S_SEL]) begin
            r_s2_ent <= n_ent;
            r_s2_eta <= n_ent ? r_eta_en : r_eta_lv;
            r_s2_d   <= n_ent ? n_dot_x : -n_dot_x;
            for (int c = 0; c < 3; c++) begin
                r_s2_nvs[c] <= n_ent ? (W + 1)'(r_s1_nv[c]) : -((W + 1)'(r_s1_nv[c]));
                r_s2_iv[c]  <= r_s1_iv[c];
            end
        end
    end

    // stage 3: d*d, eta*d and eta*i
    logic signed [W:0] n_s2_eta;
    assign n_s2_eta = $signed({1'b0, r_s2_eta});

    logic signed [2*W+1:0] r_s3_pdd;
    logic signed [2*W+1:0] r_s3_ped;
    logic signed [2*W:0]   r_s3_pei [3];
    logic [W-1:0]          r_s3_eta;
    logic signed [W:0]     r_s3_nvs [3];
    logic                  r_s3_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_MUL1]) begin
            r_s3_pdd <= r_s2_d * r_s2_d;
            r_s3_ped <= n_s2_eta * r_s2_d;
            for (int c = 0; c < 3; c++) begin
                r_s3_pei[c] <= n_s2_eta * r_s2_iv[c];
                r_s3_nvs[c] <= r_s2_nvs[c];
            end
            r_s3_eta <= r_s2_eta;
            r_s3_ent <= r_s2_ent;
        end
    end

    // stage 4: t = 1 - d^2, round eta*d and eta*i
    logic signed [W+1:0] n_t;
    assign n_t = (W + 2)'(ONE_FX) - (W + 2)'(f_round(RND_W'(r_s3_pdd)));

    logic signed [W+1:0] r_s4_t;
    logic signed [W+1:0] r_s4_ed;
    logic signed [W+1:0] r_s4_ei  [3];
    logic [W-1:0]        r_s4_eta;
    logic signed [W:0]   r_s4_nvs [3];
    logic                r_s4_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_RND1]) begin
            r_s4_t  <= n_t;
            r_s4_ed <= (W + 2)'(f_round(RND_W'(r_s3_ped)));
            for (int c = 0; c < 3; c++) begin
                r_s4_ei[c]  <= (W + 2)'(f_round(RND_W'(r_s3_pei[c])));
                r_s4_nvs[c] <= r_s3_nvs[c];
            end
            r_s4_eta <= r_s3_eta;
            r_s4_ent <= r_s3_ent;
        end
    end

    // stage 5: eta*t
    logic signed [2*W+2:0] r_s5_pu;
    logic signed [W+1:0]   r_s5_ed;
    logic signed [W+1:0]   r_s5_ei  [3];
    logic [W-1:0]          r_s5_eta;
    logic signed [W:0]     r_s5_nvs [3];
    logic                  r_s5_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_MUL2]) begin
            r_s5_pu  <= $signed({1'b0, r_s4_eta}) * r_s4_t;
            r_s5_ed  <= r_s4_ed;
            for (int c = 0; c < 3; c++) begin
                r_s5_ei[c]  <= r_s4_ei[c];
                r_s5_nvs[c] <= r_s4_nvs[c];
            end
            r_s5_eta <= r_s4_eta;
            r_s5_ent <= r_s4_ent;
        end
    end

    // stage 6: round eta*t
    logic signed [W+2:0] r_s6_u;
    logic signed [W+1:0] r_s6_ed;
    logic signed [W+1:0] r_s6_ei  [3];
    logic [W-1:0]        r_s6_eta;
    logic signed [W:0]   r_s6_nvs [3];
    logic                r_s6_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_RND2]) begin
            r_s6_u   <= (W + 3)'(f_round(RND_W'(r_s5_pu)));
            r_s6_ed  <= r_s5_ed;
            for (int c = 0; c < 3; c++) begin
                r_s6_ei[c]  <= r_s5_ei[c];
                r_s6_nvs[c] <= r_s5_nvs[c];
            end
            r_s6_eta <= r_s5_eta;
            r_s6_ent <= r_s5_ent;
        end
    end

    // stage 7: eta*(eta*t)
    logic signed [2*W+3:0] r_s7_pv;
    logic signed [W+1:0]   r_s7_ed;
    logic signed [W+1:0]   r_s7_ei  [3];
    logic signed [W:0]     r_s7_nvs [3];
    logic                  r_s7_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_MUL3]) begin
            r_s7_pv <= $signed({1'b0, r_s6_eta}) * r_s6_u;
            r_s7_ed <= r_s6_ed;
            for (int c = 0; c < 3; c++) begin
                r_s7_ei[c]  <= r_s6_ei[c];
                r_s7_nvs[c] <= r_s6_nvs[c];
            end
            r_s7_ent <= r_s6_ent;
        end
    end

    // stage 8: k, total reflection test, radicand
    logic signed [K_W-1:0] n_k;
    logic                  n_tir;
    assign n_k   = K_W'(ONE_FX) - K_W'(f_round(RND_W'(r_s7_pv)));
    assign n_tir = n_k[K_W-1];

    logic [RAD_W-1:0]    r_s8_rad;
    logic                r_s8_tir;
    logic signed [W+1:0] r_s8_ed;
    logic signed [W+1:0] r_s8_ei  [3];
    logic signed [W:0]   r_s8_nvs [3];
    logic                r_s8_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_K]) begin
            r_s8_rad <= n_tir ? '0 : n_k[RAD_W-1:0];
            r_s8_tir <= n_tir;
            r_s8_ed  <= r_s7_ed;
            for (int c = 0; c < 3; c++) begin
                r_s8_ei[c]  <= r_s7_ei[c];
                r_s8_nvs[c] <= r_s7_nvs[c];
            end
            r_s8_ent <= r_s7_ent;
        end
    end

    // square root pipeline
    logic [ROOT_W-1:0] w_root;

    rdu_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_ld       (ld[S_SQ0 +: SQ_STAGES]),
        .i_radicand (r_s8_rad),
        .o_root     (w_root)
    );

    // side data travelling alongside the square root stages
    logic signed [W+1:0] r_q_ed  [SQ_STAGES];
    logic signed [W+1:0] r_q_ei  [SQ_STAGES][3];
    logic signed [W:0]   r_q_nvs [SQ_STAGES][3];
    logic                r_q_tir [SQ_STAGES];
    logic                r_q_ent [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (ld[S_SQ0]) begin
            r_q_ed[0]  <= r_s8_ed;
            r_q_tir[0] <= r_s8_tir;
            r_q_ent[0] <= r_s8_ent;
            for (int c = 0; c < 3; c++) begin
                r_q_ei[0][c]  <= r_s8_ei[c];
                r_q_nvs[0][c] <= r_s8_nvs[c];
            end
        end
        for (int j = 1; j < SQ_STAGES; j++) begin
            if (ld[S_SQ0 + j]) begin
                r_q_ed[j]  <= r_q_ed[j-1];
                r_q_tir[j] <= r_q_tir[j-1];
                r_q_ent[j] <= r_q_ent[j-1];
                for (int c = 0; c < 3; c++) begin
                    r_q_ei[j][c]  <= r_q_ei[j-1][c];
                    r_q_nvs[j][c] <= r_q_nvs[j-1][c];
                end
            end
        end
    end

    // coefficient eta*d + sqrt(k)
    logic signed [W+2:0] n_coef;
    assign n_coef = (W + 3)'(r_q_ed[SQ_STAGES-1]) + $signed((W + 3)'(w_root));

    logic signed [W+2:0] r_c_coef;
    logic signed [W+1:0] r_c_ei  [3];
    logic signed [W:0]   r_c_nvs [3];
    logic                r_c_tir;
    logic                r_c_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_COEF]) begin
            r_c_coef <= n_coef;
            for (int c = 0; c < 3; c++) begin
                r_c_ei[c]  <= r_q_ei[SQ_STAGES-1][c];
                r_c_nvs[c] <= r_q_nvs[SQ_STAGES-1][c];
            end
            r_c_tir <= r_q_tir[SQ_STAGES-1];
            r_c_ent <= r_q_ent[SQ_STAGES-1];
        end
    end

    // normal times coefficient
    logic signed [2*W+3:0] r_m_pn [3];
    logic signed [W+1:0]   r_m_ei [3];
    logic                  r_m_tir;
    logic                  r_m_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_MULN]) begin
            for (int c = 0; c < 3; c++) begin
                r_m_pn[c] <= r_c_nvs[c] * r_c_coef;
                r_m_ei[c] <= r_c_ei[c];
            end
            r_m_tir <= r_c_tir;
            r_m_ent <= r_c_ent;
        end
    end

    // round normal term
    logic signed [W+4:0] r_r_rn [3];
    logic signed [W+1:0] r_r_ei [3];
    logic                r_r_tir;
    logic                r_r_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_RNDN]) begin
            for (int c = 0; c < 3; c++) begin
                r_r_rn[c] <= (W + 5)'(f_round(RND_W'(r_m_pn[c])));
                r_r_ei[c] <= r_m_ei[c];
            end
            r_r_tir <= r_m_tir;
            r_r_ent <= r_m_ent;
        end
    end

    // output register: eta*i - coef*n, saturated, zero on total reflection
    logic signed [SAT_W-1:0] n_diff [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_diff[c] = SAT_W'(r_r_ei[c]) - SAT_W'(r_r_rn[c]);
        end
    end

    logic signed [W-1:0] r_o_refr [3];
    logic                r_o_tir;
    logic                r_o_ent;

    always_ff @(posedge i_clk) begin
        if (ld[S_OUT]) begin
            for (int c = 0; c < 3; c++) begin
                r_o_refr[c] <= r_r_tir ? '0 : f_sat(n_diff[c]);
            end
            r_o_tir <= r_r_tir;
            r_o_ent <= r_r_ent;
        end
    end

    assign m_axis_tvalid = r_v[S_OUT];
    assign m_axis_tdata  = OUT_TW'({r_o_refr[2], r_o_refr[1], r_o_refr[0]});
    assign m_axis_tuser  = {r_o_ent, r_o_tir};

endmodule

// ===== rtl/rdu_sqrt.sv =====
`timescale 1ns / 1ps

module rdu_sqrt (
    input  logic                           i_clk,
    input  logic [rdu_pkg::SQ_STAGES-1:0]  i_ld,
    input  logic [rdu_pkg::RAD_W-1:0]      i_radicand,
    output logic [rdu_pkg::ROOT_W-1:0]     o_root
);
    import rdu_pkg::*;

    localparam int SQ_N  = SQ_STAGES * SQ_BITS;
    localparam int REM_W = SQ_N + 1;
    localparam int XW    = 2 * SQ_N;

    // stage registers: partial remainder, partial root, unused radicand bits
    logic [REM_W-1:0] r_rem  [SQ_STAGES-1];
    logic [XW-1:0]    r_x    [SQ_STAGES-1];
    logic [SQ_N-1:0]  r_root [SQ_STAGES];

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
        logic [REM_W-1:0] w_rem;
        logic [SQ_N-1:0]  w_root;
        logic [XW-1:0]    w_x;
        logic [REM_W-1:0] n_rem;
        logic [SQ_N-1:0]  n_root;
        logic [XW-1:0]    n_x;

        // stage input: fresh radicand with FRAC extra fraction bits, or previous stage
        if (j == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = XW'({i_radicand, {FRAC{1'b0}}});
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_x    = r_x[j-1];
        end

        // restoring square root, one root bit per step
        always_comb begin
            logic [REM_W-1:0] rem;
            logic [SQ_N-1:0]  root;
            logic [XW-1:0]    x;
            logic [REM_W+1:0] wrem;
            logic [REM_W+1:0] trial;
            rem  = w_rem;
            root = w_root;
            x    = w_x;
            for (int s = 0; s < SQ_BITS; s++) begin
                wrem  = {rem, x[XW-1 -: 2]};
                trial = (REM_W + 2)'({root, 2'b01});
                if (wrem >= trial) begin
                    rem  = REM_W'(wrem - trial);
                    root = {root[SQ_N-2:0], 1'b1};
                end else begin
                    rem  = REM_W'(wrem);
                    root = {root[SQ_N-2:0], 1'b0};
                end
                x = x << 2;
            end
            n_rem  = rem;
            n_root = root;
            n_x    = x;
        end

        always_ff @(posedge i_clk) begin
            if (i_ld[j]) begin
                r_root[j] <= n_root;
            end
        end

        if (j < SQ_STAGES - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_ld[j]) begin
                    r_rem[j] <= n_rem;
                    r_x[j]   <= n_x;
                end
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1][ROOT_W-1:0];

endmodule

// ===== verif/rdu_refraction_check.sv =====
`timescale 1ns / 1ps

// register indexes of the configuration port
package rdu_tb_pkg;
    localparam logic REG_INDEX_RATIO         = 1'b0;
    localparam logic REG_INDEX_RATIO_INVERSE = 1'b1;
endpackage

module rdu_refraction_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [rdu_pkg::VEC_WIDTH-1:0] i_cfg_wdata,
    input  logic                          i_ray_valid,
    input  logic                          i_ray_ready,
    // ray_dir_x, ray_dir_y, ray_dir_z, normal_x, normal_y, normal_z
    input  logic [rdu_pkg::IN_TW-1:0]     i_ray_data,
    input  logic                          i_refr_valid,
    input  logic                          i_refr_ready,
    // refr_x, refr_y, refr_z
    input  logic [rdu_pkg::OUT_TW-1:0]    i_refr_data,
    // total_reflection, entering
    input  logic [1:0]                    i_refr_user,
    output int                            o_mismatches,
    output int                            o_pending
);
    import rdu_pkg::*;
    import rdu_tb_pkg::*;

    localparam int     W    = VEC_WIDTH;
    localparam longint ONE  = ONE_FX;
    localparam longint HALF = HALF_FX;
    localparam longint VMAX = (longint'(1) << (W - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    typedef struct packed {
        logic         entering;
        logic         total_reflection;
        logic [W-1:0] refr_z;
        logic [W-1:0] refr_y;
        logic [W-1:0] refr_x;
    } t_refraction;

    // shadow copies of the index registers
    logic [W-1:0] leave_eta;
    logic [W-1:0] enter_eta;

    t_refraction expected_refractions[$];
    int          result_index;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        result_index = 0;
        leave_eta    = W'(ONE_FX);
        enter_eta    = W'(ONE_FX);
    end

    // product scaled down by FRAC bits, rounded half away from zero
    function automatic longint round_mul(input longint a, input longint b);
        logic   neg;
        longint ua;
        longint ub;
        longint r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        r   = (ua * ub + HALF) >> FRAC;
        return neg ? -r : r;
    endfunction

    // clamp to the signed vector range
    function automatic longint clamp_vec(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // floor of sqrt(k) kept at FRAC fraction bits
    function automatic longint floor_root(input longint k_val);
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        radicand = longint'(k_val) << FRAC;
        root     = 0;
        for (int s = 31; s >= 0; s--) begin
            trial = root | (longint'(1) << s);
            if (trial * trial <= radicand) root = trial;
        end
        return longint'(root);
    endfunction

    // refracted direction and flags for one ray
    function automatic t_refraction refract_predict(input logic [IN_TW-1:0] ray,
                                                    input logic [W-1:0]     leave_idx,
                                                    input logic [W-1:0]     enter_idx);
        longint      iv[3];
        longint      nv[3];
        longint      outv[3];
        longint      dot;
        longint      d;
        longint      eta;
        longint      k;
        longint      coef;
        t_refraction res;
        for (int c = 0; c < 3; c++) begin
            iv[c] = $signed(ray[c*W +: W]);
            nv[c] = $signed(ray[(c+3)*W +: W]);
        end
        dot = clamp_vec(round_mul(iv[0], nv[0]) + round_mul(iv[1], nv[1])
                        + round_mul(iv[2], nv[2]));
        res = '0;
        res.entering = (dot < 0);
        // leaving: other index, flipped normal and dot
        if (res.entering) begin
            eta = enter_idx;
            d   = dot;
        end else begin
            eta = leave_idx;
            d   = -dot;
            for (int c = 0; c < 3; c++) nv[c] = -nv[c];
        end
        k = ONE - round_mul(eta, round_mul(eta, ONE - round_mul(d, d)));
        if (k < 0) begin
            res.total_reflection = 1'b1;
            return res;
        end
        coef = round_mul(eta, d) + floor_root(k);
        for (int c = 0; c < 3; c++) begin
            outv[c] = clamp_vec(round_mul(eta, iv[c]) - round_mul(nv[c], coef));
        end
        res.refr_x = W'(outv[0]);
        res.refr_y = W'(outv[1]);
        res.refr_z = W'(outv[2]);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("MISMATCH %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic signed [W-1:0] got,
                                 input logic signed [W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_index, field, got, want));
        end
    endtask

    // track configuration, predict on ray transactions, compare on result transactions
    always @(posedge i_clk) begin
        t_refraction got;
        t_refraction want;
        if (!i_rst_n) begin
            leave_eta = W'(ONE_FX);
            enter_eta = W'(ONE_FX);
            expected_refractions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_INDEX_RATIO:         leave_eta = i_cfg_wdata;
                    REG_INDEX_RATIO_INVERSE: enter_eta = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_ray_valid && i_ray_ready) begin
                expected_refractions.push_back(refract_predict(i_ray_data, leave_eta,
                                                               enter_eta));
            end
            if (i_refr_valid && i_refr_ready) begin
                if (expected_refractions.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              result_index));
                end else begin
                    want = expected_refractions.pop_front();
                    got.refr_x           = i_refr_data[0 +: W];
                    got.refr_y           = i_refr_data[W +: W];
                    got.refr_z           = i_refr_data[2*W +: W];
                    got.total_reflection = i_refr_user[0];
                    got.entering         = i_refr_user[1];
                    compare_field("refr_x", got.refr_x, want.refr_x);
                    compare_field("refr_y", got.refr_y, want.refr_y);
                    compare_field("refr_z", got.refr_z, want.refr_z);
                    compare_field("total_reflection", got.total_reflection,
                                  want.total_reflection);
                    compare_field("entering", got.entering, want.entering);
                end
                result_index++;
            end
        end
        o_pending = expected_refractions.size();
    end

endmodule

// ===== verif/tb_refraction_direction_unit_core.sv =====
`timescale 1ns / 1ps

module tb_refraction_direction_unit_core;
    import rdu_pkg::*;
    import rdu_tb_pkg::*;

    localparam int W = VEC_WIDTH;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_addr    = 1'b0;
    logic [W-1:0]      i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches;
    int pending;

    always #1 i_clk = ~i_clk;

    refraction_direction_unit_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rdu_refraction_check u_refraction_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ray_valid  (s_axis_tvalid),
        .i_ray_ready  (s_axis_tready),
        .i_ray_data   (s_axis_tdata),
        .i_refr_valid (m_axis_tvalid),
        .i_refr_ready (m_axis_tready),
        .i_refr_data  (m_axis_tdata),
        .i_refr_user  (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // receiver backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop
    initial begin
        #200000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [IN_TW-1:0] pack_ray(input logic [W-1:0] ix, input logic [W-1:0] iy,
                                                  input logic [W-1:0] iz, input logic [W-1:0] nx,
                                                  input logic [W-1:0] ny, input logic [W-1:0] nz);
        return {nz, ny, nx, iz, iy, ix};
    endfunction

    // real to Q2.14, clamped
    function automatic logic [W-1:0] to_fx(input real r);
        real s;
        int  v;
        s = r * ONE_FX;
        if (s > 32767.0) s = 32767.0;
        if (s < -32768.0) s = -32768.0;
        v = $rtoi(s);
        return v[W-1:0];
    endfunction

    function automatic logic [3*W-1:0] rand_unit_vec();
        real x;
        real y;
        real z;
        real len;
        x   = real'($urandom_range(0, 20000)) / 10000.0 - 1.0;
        y   = real'($urandom_range(0, 20000)) / 10000.0 - 1.0;
        z   = real'($urandom_range(0, 20000)) / 10000.0 - 1.0;
        len = $sqrt(x * x + y * y + z * z);
        if (len < 0.001) begin
            x   = 0.0;
            y   = 0.0;
            z   = 1.0;
            len = 1.0;
        end
        return {to_fx(z / len), to_fx(y / len), to_fx(x / len)};
    endfunction

    // mostly unit vectors, some jittered, some raw bit patterns
    function automatic logic [IN_TW-1:0] make_random_ray();
        logic [6*W-1:0] fields;
        int             sel;
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            fields = {rand_unit_vec(), rand_unit_vec()};
            if (sel >= 70) begin
                for (int c = 0; c < 6; c++) begin
                    fields[c*W +: W] = fields[c*W +: W] + W'($urandom_range(0, 64)) - W'(32);
                end
            end
        end else begin
            for (int c = 0; c < 6; c++) begin
                case ($urandom_range(0, 3))
                    0:       fields[c*W +: W] = {1'b1, {(W-1){1'b0}}};
                    1:       fields[c*W +: W] = {1'b0, {(W-1){1'b1}}};
                    default: fields[c*W +: W] = W'($urandom);
                endcase
            end
        end
        return IN_TW'(fields);
    endfunction

    // one ray transaction, entered and left at a falling edge
    task automatic send_ray(input logic [IN_TW-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every pending result is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_indices(input logic [W-1:0] ratio, input logic [W-1:0] inverse);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_INDEX_RATIO;
        i_cfg_wdata <= ratio;
        @(negedge i_clk);
        i_cfg_addr  <= REG_INDEX_RATIO_INVERSE;
        i_cfg_wdata <= inverse;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int count, input int sender_idle, input int receiver_stall);
        send_idle_pct = sender_idle;
        stall_pct     = receiver_stall;
        repeat (count) send_ray(make_random_ray());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset indices: head-on both ways, zero and tiny dot, field extremes, grazing
        send_ray(pack_ray(0, 0, -16384, 0, 0, 16384));
        send_ray(pack_ray(0, 0, 16384, 0, 0, 16384));
        send_ray(pack_ray(0, 0, 0, 0, 0, 0));
        send_ray(pack_ray(1, 0, 0, -1, 0, 0));
        send_ray(pack_ray(32767, 32767, 32767, 32767, 32767, 32767));
        send_ray(pack_ray(-32768, -32768, -32768, -32768, -32768, -32768));
        send_ray(pack_ray(32767, 32767, 32767, -32768, -32768, -32768));
        send_ray(pack_ray(-32768, 32767, -32768, 32767, -32768, 32767));
        send_ray(pack_ray(16384, 0, 0, 0, 0, 16384));
        drain();

        // glass-like indices: total reflection when leaving obliquely
        set_indices(24576, 10923);
        send_ray(pack_ray(13107, 0, 9830, 0, 0, 16384));
        send_ray(pack_ray(1638, 0, 16302, 0, 0, 16384));
        send_ray(pack_ray(13107, 0, -9830, 0, 0, 16384));
        send_ray(pack_ray(16302, 0, -1638, 0, 0, 16384));
        drain();

        // largest indices: reflection when entering obliquely, saturation
        set_indices(16'hffff, 16'hffff);
        send_ray(pack_ray(13107, 0, -9830, 0, 0, 16384));
        send_ray(pack_ray(0, 0, 16384, 0, 0, 16384));
        send_ray(pack_ray(0, 0, -16384, 0, 0, 16384));
        send_ray(pack_ray(32767, -32768, 32767, -32768, 32767, -32768));
        drain();

        // zero indices
        set_indices(16'h0000, 16'h0000);
        send_ray(pack_ray(0, 0, -16384, 0, 0, 16384));
        send_ray(pack_ray(13107, 0, 9830, 0, 0, 16384));
        send_ray(pack_ray(32767, 32767, 32767, 32767, 32767, 32767));
        drain();

        // random phases over several index settings and idling patterns
        set_indices(24576, 10923);
        run_random(90, 0, 0);
        set_indices(16'hffff, 16'h0000);
        run_random(90, 77, 0);
        set_indices(16'h0000, 16'hffff);
        run_random(90, 0, 77);
        set_indices(21791, 12320);
        run_random(90, 27, 27);
        set_indices(W'($urandom), W'($urandom));
        run_random(90, 0, 27);
        set_indices(16384, 16384);
        run_random(100, 27, 27);

        // catch any stray result
        repeat (30) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
